### hw/rtl/sine_maclaurin_series_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sine series engine
// Shared property forms; each expects clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef SINE_MACLAURIN_SERIES_TOP_ASSERT_SVH
`define SINE_MACLAURIN_SERIES_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sms_pkg.sv
// ----------------------------------------------------------------------------
// sms_pkg
// Widths, the pipeline lane type and divisor helpers for the sine series engine.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int TERM_COUNT = 10;
  localparam int FRAC_W     = 28;
  localparam int ANGLE_W    = 31;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_W      = 32;

  // |x| <= 2^30, so the magnitude and its square fit these widths.
  localparam int AX_W   = 31;
  localparam int SQ_W   = 2 * AX_W;
  localparam int X2_W   = 33;
  // Term magnitudes stay below 16.0 for every angle in [-4,4).
  localparam int MAG_W  = 32;
  localparam int PROD_W = MAG_W + X2_W;
  localparam int ACC_W  = 40;

  // Constant division by reciprocal: n < 2^N_W, recip = floor(2^N_W / d).
  localparam int N_W     = 37;
  localparam int NL_W    = 19;
  localparam int NH_W    = N_W - NL_W;
  localparam int RECIP_W = 35;
  localparam int QA_W    = 35;
  localparam int DIV_W   = 10;
  localparam int SUM_W   = N_W + RECIP_W;

  localparam logic [N_W:0] RECIP_NUM = {1'b1, {N_W{1'b0}}};
  localparam logic [FRAC_W-1:0] RND_HALF = {1'b1, {(FRAC_W-1){1'b0}}};

  typedef struct packed {
    logic                    vld;
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic [X2_W-1:0]         x2;
    logic signed [ACC_W-1:0] acc;
  } lane_t;

  // Divisor (2i+2)(2i+3) that turns term i into term i+1.
  function automatic logic [DIV_W-1:0] term_divisor(input int idx);
    int d;
    d = (2 * idx + 2) * (2 * idx + 3);
    return DIV_W'(d);
  endfunction

  // Signed value of a sign/magnitude term, widened to the accumulator.
  function automatic logic signed [ACC_W-1:0] term_value(input logic neg,
                                                        input logic [MAG_W-1:0] mag);
    logic signed [ACC_W-1:0] ext;
    ext = $signed({{(ACC_W-MAG_W){1'b0}}, mag});
    return neg ? -ext : ext;
  endfunction

endpackage

### hw/rtl/sine_maclaurin_series_top.sv
// ----------------------------------------------------------------------------
// sine_maclaurin_series_top
// Pipelined sin(x) from the first ten Maclaurin terms, one angle per cycle unless stalled.
// Input beat: in_tdata[30:0] is the angle, signed Q3.28 radians in [-4,4).
// Output beat: out_tdata[31:0] is the saturated sine, signed Q4.28.
// Each beat is independent; no configuration and no state between beats.
// Pipeline: 49 register stages between the accepting edge and a result
// on out_tvalid: three front stages (abs, square, round), five per derived
// term (multiply, round, two reciprocal steps, remainder fix) and one
// output register.
// Throughput: one beat per cycle while the output is not stalled; every stage is registered.
// Stall: the whole pipe advances together; when out_tvalid is high and
// out_tready low, every stage holds and in_tready drops in the same cycle.
// Reset: synchronous rst_n clears all valid bits and holds in_tready low;
// the pipe is empty after.
// ----------------------------------------------------------------------------
module sine_maclaurin_series_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] angle, [31] zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] sine_value
);

  localparam int LAST = sms_pkg::TERM_COUNT - 1;

  // Bound on any result: the series stays within 1.0 plus 2^-4, i.e. 1.0625.
  localparam logic signed [sms_pkg::OUT_W-1:0] SINE_BOUND =
    sms_pkg::OUT_W'((1 << sms_pkg::FRAC_W) + (1 << (sms_pkg::FRAC_W - 4)));

  // Global advance: the pipe moves whenever the output register is free.
  logic en;

  // Front stage 1: sign and magnitude of the angle.
  logic                          f1_vld_r, f1_neg_r;
  logic [sms_pkg::AX_W-1:0]      f1_ax_r, f1_ax_nxt;
  logic [sms_pkg::ANGLE_W-1:0]   angle;

  // Front stage 2: x squared.
  logic                          f2_vld_r, f2_neg_r;
  logic [sms_pkg::AX_W-1:0]      f2_ax_r;
  logic [sms_pkg::SQ_W-1:0]      f2_sq_r, f2_sq_nxt;

  // Front stage 3: x^2 rounded to 28 fraction bits, first term is x.
  logic [sms_pkg::SQ_W-1:0]      sq_rnd;
  sms_pkg::lane_t                f3_lane_r, f3_lane_nxt;

  // Lane between term slices; entry 0 is the front end.
  sms_pkg::lane_t                lane_w [sms_pkg::TERM_COUNT];

  // Output stage.
  logic signed [sms_pkg::ACC_W-1:0] fin_sum;
  logic [sms_pkg::OUT_W-1:0]        sat_nxt;
  logic                             out_tvalid_r;
  logic [sms_pkg::OUT_W-1:0]        out_tdata_r;
  logic                             out_in_range;

  assign en        = ~out_tvalid_r | out_tready;
  assign in_tready = en & rst_n;

  assign angle     = in_tdata[sms_pkg::ANGLE_W-1:0];
  // Two's-complement magnitude; -4.0 maps to 2^30, which still fits.
  assign f1_ax_nxt = angle[sms_pkg::ANGLE_W-1] ? (~angle + 1'b1) : angle;

  assign f2_sq_nxt = sms_pkg::SQ_W'(f1_ax_r) * sms_pkg::SQ_W'(f1_ax_r);

  assign sq_rnd = f2_sq_r + sms_pkg::SQ_W'(sms_pkg::RND_HALF);

  always_comb begin
    f3_lane_nxt.vld = f2_vld_r;
    f3_lane_nxt.neg = f2_neg_r;
    f3_lane_nxt.mag = sms_pkg::MAG_W'(f2_ax_r);
    f3_lane_nxt.x2  = sq_rnd[sms_pkg::FRAC_W+sms_pkg::X2_W-1:sms_pkg::FRAC_W];
    f3_lane_nxt.acc = '0;
  end

  // Valid bits reset; the data beside them only moves with the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r      <= 1'b0;
      f2_vld_r      <= 1'b0;
      f3_lane_r.vld <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else if (en) begin
      f1_vld_r      <= in_tvalid;
      f2_vld_r      <= f1_vld_r;
      f3_lane_r.vld <= f3_lane_nxt.vld;
      out_tvalid_r  <= lane_w[LAST].vld;
    end
    if (en) begin
      f1_neg_r      <= angle[sms_pkg::ANGLE_W-1];
      f1_ax_r       <= f1_ax_nxt;
      f2_neg_r      <= f1_neg_r;
      f2_ax_r       <= f1_ax_r;
      f2_sq_r       <= f2_sq_nxt;
      f3_lane_r.neg <= f3_lane_nxt.neg;
      f3_lane_r.mag <= f3_lane_nxt.mag;
      f3_lane_r.x2  <= f3_lane_nxt.x2;
      f3_lane_r.acc <= f3_lane_nxt.acc;
      out_tdata_r   <= sat_nxt;
    end
  end

  assign lane_w[0] = f3_lane_r;

  // One slice per derived term; each divides by its own constant (2i+2)(2i+3).
  for (genvar g = 0; g < LAST; g++) begin : g_term
    localparam logic [sms_pkg::DIV_W-1:0]   Div   = sms_pkg::term_divisor(g);
    localparam logic [sms_pkg::RECIP_W-1:0] Recip =
      sms_pkg::RECIP_W'(sms_pkg::RECIP_NUM / Div);

    sms_term u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .div      (Div),
      .half     (Div >> 1),
      .recip    (Recip),
      .lane_in  (lane_w[g]),
      .lane_out (lane_w[g+1])
    );
  end

  // The last term joins the sum here; the accumulator cannot overflow
  // 40 bits for any angle, so only the 32-bit output clamp remains.
  assign fin_sum = lane_w[LAST].acc
                 + sms_pkg::term_value(lane_w[LAST].neg, lane_w[LAST].mag);

  always_comb begin
    if (fin_sum[sms_pkg::ACC_W-1:sms_pkg::OUT_W-1] == '0 ||
        fin_sum[sms_pkg::ACC_W-1:sms_pkg::OUT_W-1] == '1) begin
      sat_nxt = fin_sum[sms_pkg::OUT_W-1:0];
    end else if (fin_sum[sms_pkg::ACC_W-1]) begin
      sat_nxt = {1'b1, {(sms_pkg::OUT_W-1){1'b0}}};
    end else begin
      sat_nxt = {1'b0, {(sms_pkg::OUT_W-1){1'b1}}};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign out_in_range = ($signed(out_tdata_r) <= SINE_BOUND) &&
                        ($signed(out_tdata_r) >= -SINE_BOUND);

  `include "sine_maclaurin_series_top_assert.svh"

  // An accepted angle must occupy the first stage on the next cycle.
  `SMS_ASSERT_NEXT(a_in_enters, in_tvalid && in_tready, f1_vld_r, "accepted beat lost at entry")
  // A new result only ever comes from a valid last slice.
  `SMS_ASSERT_SAME(a_out_source, $rose(out_tvalid_r), $past(lane_w[LAST].vld), "orphan result")
  // Every result is a sine value inside [-1.0625, 1.0625].
  `SMS_ASSERT_SAME(a_out_bound, out_tvalid_r, out_in_range, "result out of sine range")

endmodule

### hw/rtl/sms_term.sv
// ----------------------------------------------------------------------------
// sms_term
// Five-stage slice that adds one series term and derives the next one.
// ----------------------------------------------------------------------------
module sms_term (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [sms_pkg::DIV_W-1:0]     div,
  input  logic [sms_pkg::DIV_W-1:0]     half,
  input  logic [sms_pkg::RECIP_W-1:0]   recip,
  input  sms_pkg::lane_t                lane_in,
  output sms_pkg::lane_t                lane_out
);

  // Stage 1: accumulate this term, multiply its magnitude by x^2.
  logic                                vld1_r, neg1_r;
  logic [sms_pkg::X2_W-1:0]            x2_1_r;
  logic signed [sms_pkg::ACC_W-1:0]    acc1_r, acc1_nxt;
  logic [sms_pkg::PROD_W-1:0]          prod1_r, prod1_nxt;

  // Stage 2: round to 28 fraction bits and add half the divisor.
  logic                                vld2_r, neg2_r;
  logic [sms_pkg::X2_W-1:0]            x2_2_r;
  logic signed [sms_pkg::ACC_W-1:0]    acc2_r;
  logic [sms_pkg::N_W-1:0]             n2_r, n2_nxt;
  logic [sms_pkg::PROD_W:0]            rnd2;

  // Stage 3: two partial products of n and the reciprocal.
  logic                                vld3_r, neg3_r;
  logic [sms_pkg::X2_W-1:0]            x2_3_r;
  logic signed [sms_pkg::ACC_W-1:0]    acc3_r;
  logic [sms_pkg::N_W-1:0]             n3_r;
  logic [sms_pkg::NL_W+sms_pkg::RECIP_W-1:0] pl3_r, pl3_nxt;
  logic [sms_pkg::NH_W+sms_pkg::RECIP_W-1:0] ph3_r, ph3_nxt;

  // Stage 4: quotient estimate, low by at most one.
  logic                                vld4_r, neg4_r;
  logic [sms_pkg::X2_W-1:0]            x2_4_r;
  logic signed [sms_pkg::ACC_W-1:0]    acc4_r;
  logic [sms_pkg::N_W-1:0]             n4_r;
  logic [sms_pkg::QA_W-1:0]            qa4_r, qa4_nxt;
  logic [sms_pkg::SUM_W-1:0]           sum4;

  // Stage 5: remainder check and the next term.
  logic [sms_pkg::QA_W+sms_pkg::DIV_W-1:0] dq5;
  logic [sms_pkg::N_W-1:0]             rem5;
  logic [sms_pkg::QA_W-1:0]            nm5;
  sms_pkg::lane_t                      lane_r, lane_nxt;

  // All valid bits of the slice, oldest stage last.
  logic [4:0]                          vld_vec;

  assign acc1_nxt  = lane_in.acc + sms_pkg::term_value(lane_in.neg, lane_in.mag);
  assign prod1_nxt = sms_pkg::PROD_W'(lane_in.mag) * sms_pkg::PROD_W'(lane_in.x2);

  assign rnd2   = {1'b0, prod1_r} + (sms_pkg::PROD_W+1)'(sms_pkg::RND_HALF);
  assign n2_nxt = rnd2[sms_pkg::FRAC_W+sms_pkg::N_W-1:sms_pkg::FRAC_W]
                + sms_pkg::N_W'(half);

  assign pl3_nxt = (sms_pkg::NL_W+sms_pkg::RECIP_W)'(n2_r[sms_pkg::NL_W-1:0])
                 * (sms_pkg::NL_W+sms_pkg::RECIP_W)'(recip);
  assign ph3_nxt = (sms_pkg::NH_W+sms_pkg::RECIP_W)'(n2_r[sms_pkg::N_W-1:sms_pkg::NL_W])
                 * (sms_pkg::NH_W+sms_pkg::RECIP_W)'(recip);

  assign sum4    = {ph3_r, {sms_pkg::NL_W{1'b0}}} + sms_pkg::SUM_W'(pl3_r);
  assign qa4_nxt = sum4[sms_pkg::SUM_W-1:sms_pkg::N_W];

  assign dq5  = (sms_pkg::QA_W+sms_pkg::DIV_W)'(qa4_r)
              * (sms_pkg::QA_W+sms_pkg::DIV_W)'(div);
  assign rem5 = n4_r - dq5[sms_pkg::N_W-1:0];
  assign nm5  = qa4_r + sms_pkg::QA_W'(rem5 >= sms_pkg::N_W'(div));

  always_comb begin
    lane_nxt.vld = vld4_r;
    lane_nxt.neg = ~neg4_r & (nm5 != '0);
    lane_nxt.mag = nm5[sms_pkg::MAG_W-1:0];
    lane_nxt.x2  = x2_4_r;
    lane_nxt.acc = acc4_r;
  end

  // Valid bits reset; the data beside them only moves with the pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r     <= 1'b0;
      vld2_r     <= 1'b0;
      vld3_r     <= 1'b0;
      vld4_r     <= 1'b0;
      lane_r.vld <= 1'b0;
    end else if (en) begin
      vld1_r     <= lane_in.vld;
      vld2_r     <= vld1_r;
      vld3_r     <= vld2_r;
      vld4_r     <= vld3_r;
      lane_r.vld <= lane_nxt.vld;
    end
    if (en) begin
      neg1_r     <= lane_in.neg;
      x2_1_r     <= lane_in.x2;
      acc1_r     <= acc1_nxt;
      prod1_r    <= prod1_nxt;
      neg2_r     <= neg1_r;
      x2_2_r     <= x2_1_r;
      acc2_r     <= acc1_r;
      n2_r       <= n2_nxt;
      neg3_r     <= neg2_r;
      x2_3_r     <= x2_2_r;
      acc3_r     <= acc2_r;
      n3_r       <= n2_r;
      pl3_r      <= pl3_nxt;
      ph3_r      <= ph3_nxt;
      neg4_r     <= neg3_r;
      x2_4_r     <= x2_3_r;
      acc4_r     <= acc3_r;
      n4_r       <= n3_r;
      qa4_r      <= qa4_nxt;
      lane_r.neg <= lane_nxt.neg;
      lane_r.mag <= lane_nxt.mag;
      lane_r.x2  <= lane_nxt.x2;
      lane_r.acc <= lane_nxt.acc;
    end
  end

  assign lane_out = lane_r;

  assign vld_vec = {vld1_r, vld2_r, vld3_r, vld4_r, lane_r.vld};

  `include "sine_maclaurin_series_top_assert.svh"

  // The reciprocal estimate must be at most one below the true quotient.
  `SMS_ASSERT_SAME(a_rem_range, vld4_r, rem5 < {div, 1'b0}, "estimate off by two")
  // The next term magnitude must fit the magnitude field.
  `SMS_ASSERT_SAME(a_mag_fit, vld4_r, nm5[sms_pkg::QA_W-1:sms_pkg::MAG_W] == '0, "term too wide")
  // A stall freezes every valid bit of the slice.
  `SMS_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_vec), "slice moved during stall")

endmodule
